>>> rtl/decimal_precision_square_root_defines.svh
// Assertion macros for the decimal precision square root block.
// Included by modules that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef DECIMAL_PRECISION_SQUARE_ROOT_DEFINES_SVH
`define DECIMAL_PRECISION_SQUARE_ROOT_DEFINES_SVH

// same-cycle implication
`define DPSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DPSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dpsr_pkg.sv
// Shared types and constants of the decimal precision square root block.
// Used by the controller, the datapath and the top level; depends on nothing.
package dpsr_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned INT_BITS   = 16;
  localparam int unsigned MAX_PLACES = 6;

  localparam int unsigned RAD_W  = INT_BITS + FRAC_BITS;
  localparam int unsigned PL_W   = 3;
  localparam int unsigned ROOT_W = 28;
  localparam int unsigned SQ_W   = 2 * ROOT_W;
  localparam int unsigned T_W    = SQ_W + FRAC_BITS;
  localparam int unsigned IBITS  = (INT_BITS + 1) / 2;
  localparam int unsigned BIT_W  = 3;
  localparam int unsigned DIG_W  = 4;

  localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(IBITS - 1);
  localparam logic [DIG_W-1:0] DIG_MAX = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SCALE_A,
    ST_SCALE_B,
    ST_STEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             load;
    logic             search;
    logic             scale_a;
    logic             scale_b;
    logic             step;
    logic             out_load;
    logic [BIT_W-1:0] bit_idx;
  } cmd_t;

  typedef struct packed {
    logic            fit;
    logic [PL_W-1:0] places;
  } status_t;

endpackage

>>> rtl/decimal_precision_square_root.sv
// Each accepted beat goes through one acceptance step, 8 integer search steps, two scaling
// steps and the 1 to 9 digit steps of each decimal place, then a done step that loads the
// result register; the done step waits while an earlier result is held by output back-pressure.
// The square updates of the search and digit steps share a single adder and compare. Squares are
// kept incrementally, so no multiplier is used. No new beat is taken until the result is loaded;
// the next beat is taken while a result waits.
// Top level: joins dpsr_ctrl and dpsr_datapath; depends on dpsr_pkg.
module decimal_precision_square_root (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // radicand[31:0], decimal_places[34:32], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // root_scaled[27:0], is_exact[28], zero fill
);
  import dpsr_pkg::*;

  cmd_t              cmd;
  status_t           status;
  logic [ROOT_W-1:0] root_scaled;
  logic              is_exact;

  dpsr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  dpsr_datapath u_datapath (
    .clk            (clk),
    .radicand       (in_tdata[RAD_W-1:0]),
    .decimal_places (in_tdata[RAD_W+PL_W-1:RAD_W]),
    .cmd            (cmd),
    .status         (status),
    .root_scaled    (root_scaled),
    .is_exact       (is_exact)
  );

  assign out_tdata = {3'b000, is_exact, root_scaled};

endmodule

>>> rtl/dpsr_datapath.sv
// Datapath: root, square and scaled radicand registers, one shared square/compare adder.
// Driven by dpsr_ctrl through dpsr_pkg::cmd_t; reports dpsr_pkg::status_t.
module dpsr_datapath (
  input  logic                        clk,
  input  logic [dpsr_pkg::RAD_W-1:0]  radicand,
  input  logic [dpsr_pkg::PL_W-1:0]   decimal_places,
  input  dpsr_pkg::cmd_t              cmd,
  output dpsr_pkg::status_t           status,
  output logic [dpsr_pkg::ROOT_W-1:0] root_scaled,
  output logic                        is_exact
);
  import dpsr_pkg::*;

  logic [ROOT_W-1:0] q_r, q_nxt;
  logic [SQ_W-1:0]   s_r, s_nxt;
  logic [T_W-1:0]    t_r, t_nxt;
  logic [PL_W-1:0]   places_r, places_nxt;
  logic [ROOT_W-1:0] root_r;
  logic              exact_r;

  logic [ROOT_W-1:0] cand_q;
  logic [SQ_W-1:0]   addend;
  logic [SQ_W-1:0]   cand_s;
  logic              fit;
  logic              exact;

  always_comb begin
    if (cmd.search) begin
      cand_q = q_r | (ROOT_W'(1) << cmd.bit_idx);
      addend = (SQ_W'(q_r) << ({1'b0, cmd.bit_idx} + 4'd1))
             + (SQ_W'(1) << {cmd.bit_idx, 1'b0});
    end else begin
      cand_q = q_r + ROOT_W'(1);
      addend = (SQ_W'(q_r) << 1) + SQ_W'(1);
    end
    cand_s = s_r + addend;
    fit    = {cand_s, {FRAC_BITS{1'b0}}} <= t_r;
    exact  = {s_r, {FRAC_BITS{1'b0}}} == t_r;
  end

  always_comb begin
    q_nxt      = q_r;
    s_nxt      = s_r;
    t_nxt      = t_r;
    places_nxt = places_r;
    if (cmd.load) begin
      q_nxt      = '0;
      s_nxt      = '0;
      t_nxt      = T_W'(radicand);
      places_nxt = (decimal_places > PL_W'(MAX_PLACES)) ? PL_W'(MAX_PLACES) : decimal_places;
    end else if ((cmd.search || cmd.step) && fit) begin
      q_nxt = cand_q;
      s_nxt = cand_s;
    end else if (cmd.scale_a || cmd.scale_b) begin
      s_nxt = (s_r << 3) + (s_r << 1);
      t_nxt = (t_r << 3) + (t_r << 1);
      if (cmd.scale_a) begin
        q_nxt = (q_r << 3) + (q_r << 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r      <= q_nxt;
    s_r      <= s_nxt;
    t_r      <= t_nxt;
    places_r <= places_nxt;
    if (cmd.out_load) begin
      root_r  <= q_r;
      exact_r <= exact;
    end
  end

  assign status.fit    = fit;
  assign status.places = places_r;
  assign root_scaled   = root_r;
  assign is_exact      = exact_r;

endmodule

>>> rtl/dpsr_ctrl.sv
// Controller: sequences integer search, decimal scaling and digit steps, owns handshakes.
// Uses dpsr_pkg types and the assertion macros of the defines header.
`include "decimal_precision_square_root_defines.svh"

module dpsr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output dpsr_pkg::cmd_t    cmd,
  input  dpsr_pkg::status_t status
);
  import dpsr_pkg::*;

  state_t            state_r, state_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [PL_W-1:0]   place_r, place_nxt;
  logic [DIG_W-1:0]  dig_r, dig_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bit_r       <= '0;
      place_r     <= '0;
      dig_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_r       <= bit_nxt;
      place_r     <= place_nxt;
      dig_r       <= dig_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    bit_nxt       = bit_r;
    place_nxt     = place_r;
    dig_nxt       = dig_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    cmd           = '0;
    cmd.bit_idx   = bit_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          bit_nxt   = BIT_TOP;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (bit_r == '0) begin
          if (status.places == '0) begin
            state_nxt = ST_DONE;
          end else begin
            place_nxt = PL_W'(1);
            state_nxt = ST_SCALE_A;
          end
        end else begin
          bit_nxt = bit_r - BIT_W'(1);
        end
      end
      ST_SCALE_A: begin
        cmd.scale_a = 1'b1;
        state_nxt   = ST_SCALE_B;
      end
      ST_SCALE_B: begin
        cmd.scale_b = 1'b1;
        dig_nxt     = '0;
        state_nxt   = ST_STEP;
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        if (!status.fit || dig_r == DIG_MAX) begin
          if (place_r == status.places) begin
            state_nxt = ST_DONE;
          end else begin
            place_nxt = place_r + PL_W'(1);
            state_nxt = ST_SCALE_A;
          end
        end else begin
          dig_nxt = dig_r + DIG_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

  `DPSR_ASSERT_NOW(a_dig_bound, state_r == ST_STEP, dig_r <= DIG_MAX, "digit step count overran")
  `DPSR_ASSERT_NOW(a_place_bound, state_r == ST_STEP || state_r == ST_SCALE_A, place_r != '0 && place_r <= status.places, "place counter out of range")
  `DPSR_ASSERT_NOW(a_out_free, cmd.out_load, !out_valid_r || out_tready, "result loaded over a pending beat")
  `DPSR_ASSERT_NEXT(a_start, state_r == ST_IDLE && in_tvalid, state_r == ST_SEARCH && bit_r == BIT_TOP, "search did not start after accept")

endmodule
